@@ sv/rcv_pkg.sv @@
// Shared types and constants for the record checksum verifier.
// Depends on nothing; imported by record_checksum_verifier.
package rcv_pkg;

    localparam int RCV_MAX_RECORD = 256;
    localparam logic [15:0] RCV_CAPACITY_RESET = 16'd256;

    // Result queue: one input beat can produce up to two result beats.
    localparam int RCV_OQ_DEPTH = 4;
    localparam int RCV_OQ_AW = $clog2(RCV_OQ_DEPTH);
    localparam int RCV_OQ_CW = $clog2(RCV_OQ_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAXREC   = 3'd2,
        ST_CAP      = 3'd3,
        ST_MISMATCH = 3'd4
    } rcv_status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } rcv_in_t;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  data_byte;
        logic [2:0]  status_code;
        logic [15:0] payload_length;
    } rcv_out_t;

endpackage

@@ sv/record_checksum_verifier.sv @@
// Record checksum verifier: parses length-prefixed records byte by byte and
// checks their 16-bit additive checksum. Depends on rcv_pkg.
//
// Channel   Direction  Handshake             Beat
// in        sink       in_valid / in_stall   one raw byte of the record file
// out       source     out_valid / out_stall one payload byte or one status
// cfg       sink       cfg_valid / cfg_ready capacity_bytes write data
//
// One input byte is taken per cycle; its results are computed in the same
// cycle and written into a four-entry result queue, which drives the output.
// in_stall rises while fewer than two queue entries are free, since a payload
// byte ending the file yields two results. Output stalls fill the queue,
// then raise in_stall. Reset clears record state and sets capacity to 256.
module record_checksum_verifier
    import rcv_pkg::*;
#(
    parameter int MAX_RECORD = RCV_MAX_RECORD
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  rcv_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output rcv_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    typedef enum logic [5:0] {
        PH_LEN_LO  = 6'b000001,
        PH_LEN_HI  = 6'b000010,
        PH_PAYLOAD = 6'b000100,
        PH_SUM_LO  = 6'b001000,
        PH_SUM_HI  = 6'b010000,
        PH_SKIP    = 6'b100000
    } phase_t;

    localparam logic [16:0] MaxTotal = 17'(MAX_RECORD);

    phase_t      phase_reg, phase_next;
    logic [15:0] capacity_reg;
    logic [15:0] len_reg, len_next;
    logic [15:0] seen_reg, seen_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  stored_lo_reg, stored_lo_next;

    rcv_out_t              oq_reg [RCV_OQ_DEPTH];
    logic [RCV_OQ_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [RCV_OQ_CW-1:0]  count_reg;

    logic        in_fire, out_fire;
    logic        has_prim, has_short;
    rcv_out_t    prim, res_a, res_b;
    logic [1:0]  push_cnt;
    logic [16:0] total;
    logic [7:0]  b;

    assign cfg_ready = 1'b1;
    assign in_stall  = (count_reg > RCV_OQ_CW'(RCV_OQ_DEPTH - 2));
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && !out_stall;
    assign out_data  = oq_reg[rd_ptr_reg];
    assign b         = in_data.byte_value;

    always_comb
    begin
        phase_next     = phase_reg;
        len_next       = len_reg;
        seen_next      = seen_reg;
        sum_next       = sum_reg;
        stored_lo_next = stored_lo_reg;
        has_prim       = 1'b0;
        prim           = '0;
        total          = '0;

        unique case (phase_reg)
            PH_LEN_LO:
            begin
                len_next   = {8'd0, b};
                sum_next   = {8'd0, b};
                seen_next  = '0;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next = {b, len_reg[7:0]};
                sum_next = sum_reg + {8'd0, b};
                total    = {1'b0, len_next} + 17'd2;
                if (total > MaxTotal)
                begin
                    has_prim         = 1'b1;
                    prim.is_status   = 1'b1;
                    prim.status_code = ST_MAXREC;
                    phase_next       = PH_SKIP;
                end
                else if (total > {1'b0, capacity_reg})
                begin
                    has_prim         = 1'b1;
                    prim.is_status   = 1'b1;
                    prim.status_code = ST_CAP;
                    phase_next       = PH_SKIP;
                end
                else
                begin
                    phase_next = (len_next == '0) ? PH_SUM_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                has_prim       = 1'b1;
                prim.data_byte = b;
                sum_next       = sum_reg + {8'd0, b};
                seen_next      = seen_reg + 16'd1;
                if (seen_next >= len_reg)
                begin
                    phase_next = PH_SUM_LO;
                end
            end
            PH_SUM_LO:
            begin
                stored_lo_next = b;
                phase_next     = PH_SUM_HI;
            end
            PH_SUM_HI:
            begin
                has_prim       = 1'b1;
                prim.is_status = 1'b1;
                if ({b, stored_lo_reg} == sum_reg)
                begin
                    prim.status_code    = ST_OK;
                    prim.payload_length = len_reg;
                end
                else
                begin
                    prim.status_code = ST_MISMATCH;
                end
                phase_next = PH_SKIP;
            end
            default:
            begin
            end
        endcase

        // The file ended before the record was complete.
        has_short = in_data.last_byte && (phase_next != PH_SKIP);

        if (in_data.last_byte)
        begin
            phase_next     = PH_LEN_LO;
            len_next       = '0;
            seen_next      = '0;
            sum_next       = '0;
            stored_lo_next = '0;
        end
    end

    always_comb
    begin
        rcv_out_t short_res;
        short_res             = '0;
        short_res.is_status   = 1'b1;
        short_res.status_code = ST_SHORT;
        res_a    = has_prim ? prim : short_res;
        res_b    = short_res;
        push_cnt = in_fire ? ({1'b0, has_prim} + {1'b0, has_short}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN_LO;
            capacity_reg  <= RCV_CAPACITY_RESET;
            len_reg       <= '0;
            seen_reg      <= '0;
            sum_reg       <= '0;
            stored_lo_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                len_reg       <= len_next;
                seen_reg      <= seen_next;
                sum_reg       <= sum_next;
                stored_lo_reg <= stored_lo_next;
            end
            wr_ptr_reg <= wr_ptr_reg + RCV_OQ_AW'(push_cnt);
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + RCV_OQ_AW'(1);
            end
            count_reg <= count_reg + RCV_OQ_CW'(push_cnt) - RCV_OQ_CW'(out_fire);
        end
    end

    // Queue storage needs no reset; entries are read only after being written.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            oq_reg[wr_ptr_reg] <= res_a;
        end
        if (push_cnt == 2'd2)
        begin
            oq_reg[wr_ptr_reg + RCV_OQ_AW'(1)] <= res_b;
        end
    end

endmodule

@@ bench/record_checksum_verifier_checker.sv @@
`timescale 1ns / 1ps
// Watches the record checksum verifier's channels, predicts the result beats
// of every accepted input byte and compares them with what comes out.
// Depends on rcv_pkg.
module record_checksum_verifier_checker
    import rcv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  rcv_in_t     in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  rcv_out_t    out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          results_owed
);

    typedef enum logic [2:0] {
        REC_LEN_LO  = 3'd0,
        REC_LEN_HI  = 3'd1,
        REC_PAYLOAD = 3'd2,
        REC_SUM_LO  = 3'd3,
        REC_SUM_HI  = 3'd4,
        REC_SKIP    = 3'd5
    } rec_phase_t;

    rec_phase_t  phase;
    logic [15:0] capacity;
    logic [15:0] decl_len;
    logic [15:0] payload_seen;
    logic [15:0] run_sum;
    logic [7:0]  sum_lo;
    rcv_out_t    owed_results[$];

    function automatic rcv_out_t status_beat(rcv_status_t code, logic [15:0] len);
        rcv_out_t r;
        r = '0;
        r.is_status = 1'b1;
        r.status_code = code;
        r.payload_length = len;
        return r;
    endfunction

    task automatic clear_record();
        phase = REC_LEN_LO;
        decl_len = '0;
        payload_seen = '0;
        run_sum = '0;
        sum_lo = '0;
    endtask

    task automatic parse_record_byte(rcv_in_t beat);
        rcv_out_t data_res;
        int       total;
        case (phase)
            REC_LEN_LO:
            begin
                decl_len = {8'h00, beat.byte_value};
                run_sum = {8'h00, beat.byte_value};
                payload_seen = '0;
                phase = REC_LEN_HI;
            end
            REC_LEN_HI:
            begin
                decl_len[15:8] = beat.byte_value;
                run_sum = run_sum + {8'h00, beat.byte_value};
                total = int'(decl_len) + 2;
                // The record size limit is tested before the caller's capacity.
                if (total > RCV_MAX_RECORD)
                begin
                    owed_results.push_back(status_beat(ST_MAXREC, 16'd0));
                    phase = REC_SKIP;
                end
                else if (total > int'(capacity))
                begin
                    owed_results.push_back(status_beat(ST_CAP, 16'd0));
                    phase = REC_SKIP;
                end
                else
                begin
                    phase = (decl_len == 16'd0) ? REC_SUM_LO : REC_PAYLOAD;
                end
            end
            REC_PAYLOAD:
            begin
                data_res = '0;
                data_res.data_byte = beat.byte_value;
                owed_results.push_back(data_res);
                run_sum = run_sum + {8'h00, beat.byte_value};
                payload_seen = payload_seen + 16'd1;
                if (payload_seen >= decl_len)
                    phase = REC_SUM_LO;
            end
            REC_SUM_LO:
            begin
                sum_lo = beat.byte_value;
                phase = REC_SUM_HI;
            end
            REC_SUM_HI:
            begin
                if ({beat.byte_value, sum_lo} == run_sum)
                    owed_results.push_back(status_beat(ST_OK, decl_len));
                else
                    owed_results.push_back(status_beat(ST_MISMATCH, 16'd0));
                phase = REC_SKIP;
            end
            default:
            begin
            end
        endcase

        // The end of the file before the checksum is complete means a short record.
        if (beat.last_byte)
        begin
            if (phase != REC_SKIP)
                owed_results.push_back(status_beat(ST_SHORT, 16'd0));
            clear_record();
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rcv_out_t want;
        if (!rst_n)
        begin
            capacity = RCV_CAPACITY_RESET;
            clear_record();
            owed_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;

            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result beat with nothing owed: %h", out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("is_status", want.is_status, out_data.is_status);
                    check_field("data_byte", want.data_byte, out_data.data_byte);
                    check_field("status_code", want.status_code, out_data.status_code);
                    check_field("payload_length", want.payload_length,
                                out_data.payload_length);
                end
            end

            if (in_valid && !in_stall)
                parse_record_byte(in_data);
        end
        results_owed = owed_results.size();
    end

endmodule

@@ bench/record_checksum_verifier_tb.sv @@
`timescale 1ns / 1ps
// Top of the record checksum verifier bench: clock, reset, byte stimulus,
// capacity writes and the verdict. Depends on rcv_pkg, the block and the checker.
module record_checksum_verifier_tb;
    import rcv_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    rcv_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    rcv_out_t    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int          mismatch_count;
    int          results_owed;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    int          bytes_sent = 0;
    logic [15:0] cap_now = RCV_CAPACITY_RESET;

    always #5 clk = ~clk;

    record_checksum_verifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    record_checksum_verifier_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Receiver: a pending hold-off stalls every cycle, otherwise stalls at random.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("[record_checksum_verifier] ERROR");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.byte_value <= value;
        in_data.last_byte <= last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_file(input byte_q_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cap_now = value;
    endtask

    task automatic send_random_file();
        int          kind;
        int          r;
        int          n;
        int          len;
        logic [15:0] len_w;
        logic [15:0] sum;
        logic [7:0]  v;
        byte_q_t     bytes;
        kind = $urandom_range(99);
        // Noise: raw bytes with the end-of-file flag scattered among them.
        if (kind < 8)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom), (i == n - 1) || ($urandom_range(3) == 0));
            return;
        end

        r = $urandom_range(99);
        if (r < 80)
            len = $urandom_range(0, 12);
        else if (r < 93)
            len = $urandom_range(13, 60);
        else if (r < 97)
            len = $urandom_range(200, 254);
        else
            len = $urandom_range(255, 65535);
        len_w = 16'(len);
        bytes.push_back(len_w[7:0]);
        bytes.push_back(len_w[15:8]);
        sum = {8'h00, len_w[7:0]} + {8'h00, len_w[15:8]};

        // A rejected length skips the rest, so only a few junk bytes follow it.
        if (len + 2 > RCV_MAX_RECORD || len + 2 > int'(cap_now))
        begin
            repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
            send_file(bytes);
            return;
        end

        for (int i = 0; i < len; i++)
        begin
            v = 8'($urandom);
            bytes.push_back(v);
            sum = sum + {8'h00, v};
        end
        if ($urandom_range(99) < 12)
            sum = sum ^ (16'h0001 << $urandom_range(15));
        bytes.push_back(sum[7:0]);
        bytes.push_back(sum[15:8]);

        r = $urandom_range(99);
        if (r < 12)
        begin
            n = $urandom_range(1, bytes.size() - 1);
            while (bytes.size() > n)
                void'(bytes.pop_back());
        end
        else if (r < 22)
        begin
            repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
        end
        send_file(bytes);
    endtask

    task automatic run_random(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_random_file();
    endtask

    initial
    begin
        byte_q_t bytes;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 53;

        // Empty record, then a checksum that carries into the high byte.
        bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_file(bytes);
        bytes = '{8'h01, 8'h00, 8'hFF, 8'h00, 8'h01};
        send_file(bytes);
        bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        send_file(bytes);
        // Length one past the record limit, file ending on the length byte.
        bytes = '{8'hFF, 8'h00};
        send_file(bytes);
        // File ends inside the payload, then inside the length.
        bytes = '{8'h02, 8'h00, 8'h11};
        send_file(bytes);
        bytes = '{8'h7E};
        send_file(bytes);
        // Trailing byte after a complete record is ignored.
        bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h55};
        send_file(bytes);
        wait_results();

        write_capacity(16'd0);
        bytes = '{8'h00, 8'h00};
        send_file(bytes);
        bytes = '{8'hFF, 8'hFF, 8'h12};
        send_file(bytes);
        wait_results();

        write_capacity(16'hFFFF);
        run_random(200);
        wait_results();

        send_idle_pct = 53;
        recv_idle_pct = 24;
        write_capacity(16'($urandom_range(2, 40)));
        run_random(200);
        wait_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(16'd256);
        // Long receiver hold-off while bytes keep coming fills the result queue.
        hold_cycles = 80;
        run_random(200);
        wait_results();

        if (mismatch_count == 0 && results_owed == 0)
            $display("[record_checksum_verifier] OK");
        else
            $display("[record_checksum_verifier] ERROR");
        $finish;
    end

endmodule
